@@ design/prbt_pkg.sv @@
// prbt_pkg: types and constants for the packet round block tracker
// no dependencies
package prbt_pkg;

    // ring slots and client table size
    localparam int SLOTS       = 16;
    localparam int MAX_CLIENTS = 16;

    // result kinds
    localparam logic [2:0] KIND_ACCEPT  = 3'd0;
    localparam logic [2:0] KIND_STALE   = 3'd1;
    localparam logic [2:0] KIND_LEARNED = 3'd2;
    localparam logic [2:0] KIND_CLOSED  = 3'd3;
    localparam logic [2:0] KIND_FLUSHED = 3'd4;

    // register indexes
    localparam logic [2:0] REG_PPR  = 3'd0;
    localparam logic [2:0] REG_RPB  = 3'd1;
    localparam logic [2:0] REG_SPR  = 3'd2;
    localparam logic [2:0] REG_FULL = 3'd3;
    localparam logic [2:0] REG_NEAR = 3'd4;
    localparam logic [2:0] REG_PEND = 3'd5;

    localparam logic [30:0] ROUND_MASK = 31'h7FFF_FFFF;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_READ, ST_DECIDE, ST_DIV, ST_OFFS, ST_EMIT_A,
        ST_CLOSE, ST_COUNT, ST_SCAN_RD, ST_SCAN, ST_NEXT_DIV, ST_NEXT_OFFS,
        ST_EMIT_N
    } t_state;

endpackage

@@ design/packet_round_block_tracker_core.sv @@
// packet_round_block_tracker_core: top level of the packet round block tracker
// depends on prbt_pkg
//
// One header is taken when i_start is high, o_busy is low and i_client is in
// range. A client's first header only learns its group. A header for the
// current round or a stale one gives its word after the bit-serial divider
// turns a round number into a slot and an offset (31 steps). A closing header
// adds a count sweep and a flush scan of the slots and a second division for
// the next round; when the last packet index closes the round, no accept word
// for the new round follows. Closed and flushed words leave through a one-word
// holding register so the final word of a header can be marked. Results leave
// one per cycle on o_valid and cannot be held off. After reset the block
// clears the slot memory before it takes the first header.
module packet_round_block_tracker_core
    import prbt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic [3:0]  i_client,
    input  logic [7:0]  i_group,
    input  logic [30:0] i_round_seq,
    input  logic [11:0] i_packet_index,
    output logic        o_valid,
    output logic [2:0]  o_kind,
    output logic [3:0]  o_source,
    output logic        o_group_mismatch,
    output logic [3:0]  o_slot,
    output logic [21:0] o_time_offset,
    output logic [11:0] o_payload_index,
    output logic [15:0] o_count,
    output logic        o_short_round,
    output logic        o_last
);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;

    // configuration registers
    logic [12:0] r_ppr, r_spr;
    logic [10:0] r_rpb;
    logic [15:0] r_full, r_near;
    logic [4:0]  r_pend;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppr <= 13'd16; r_rpb <= 11'd8; r_spr <= 13'd16;
            r_full <= 16'd128; r_near <= 16'd120; r_pend <= 5'd4;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PPR:  r_ppr  <= i_cfg_data[12:0];
                REG_RPB:  r_rpb  <= i_cfg_data[10:0];
                REG_SPR:  r_spr  <= i_cfg_data[12:0];
                REG_FULL: r_full <= i_cfg_data;
                REG_NEAR: r_near <= i_cfg_data;
                REG_PEND: r_pend <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // client memory: group, round, received in one word
    logic [51:0] client_mem [MAX_CLIENTS];
    logic [51:0] r_cl_rd;
    logic        cl_we;
    logic [51:0] cl_wd;
    // started bits reset at once
    logic [MAX_CLIENTS-1:0] r_started;

    // slot memory
    logic [15:0] slot_mem [SLOTS];
    logic [15:0] r_sl_rd;
    logic        sl_we;
    logic [SW-1:0] sl_wa, sl_ra;
    logic [15:0] sl_wd;

    // latched header
    logic [CW-1:0] r_c;
    logic [7:0]    r_g;
    logic [30:0]   r_rs;
    logic [11:0]   r_pi;

    t_state r_st, n_st;
    logic [SW:0]   r_i;        // sweep index
    logic [30:0]   r_cur;
    logic [12:0]   r_rcv;
    logic          r_mis, r_newer, r_lastp;
    logic [SW-1:0] r_cslot;
    logic [5:0]    r_dcnt;
    logic [30:0]   r_q;
    logic [11:0]   r_rem;
    logic [21:0]   r_toff;
    logic signed [7:0] r_nz;

    // held closed or flushed word, sent once the next one is known
    logic [2:0]    r_h_kind;
    logic [3:0]    r_h_slot;
    logic [21:0]   r_h_toff;
    logic [15:0]   r_h_count;
    logic          r_h_short;

    wire [10:0] rpb = (r_rpb == 11'd0) ? 11'd1 : r_rpb;

    // divider step: restoring, one quotient bit a cycle
    logic [11:0] d_sh;
    logic [11:0] d_sub;
    logic        d_ge;
    always_comb begin
        d_sh  = {r_rem[10:0], r_q[30]};
        d_ge  = ({r_rem[11], d_sh} >= {2'b0, rpb});
        d_sub = 12'({r_rem[11], d_sh} - {2'b0, rpb});
    end

    wire [CW-1:0] ci = i_client[CW-1:0];
    wire in_range = (32'(i_client) < MAX_CLIENTS);

    // memories
    always_ff @(posedge i_clk) begin
        if (cl_we) client_mem[r_c] <= cl_wd;
        r_cl_rd <= client_mem[(r_st == ST_IDLE) ? ci : r_c];
        if (sl_we) slot_mem[sl_wa] <= sl_wd;
        r_sl_rd <= slot_mem[sl_ra];
    end

    // slot full / near-full test for the current scanned entry
    wire [15:0] sv = r_sl_rd;
    wire flush = (sv == r_full) ||
                 ((r_nz >= $signed({3'b0, r_pend})) && (sv >= r_near));

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_CLEAR:   if (r_i == (SW+1)'(SLOTS - 1)) n_st = ST_IDLE;
            ST_IDLE:    if (i_start && in_range) n_st = ST_READ;
            ST_READ:    n_st = ST_DECIDE;
            ST_DECIDE:  n_st = (!r_started[r_c]) ? ST_IDLE : ST_DIV;
            ST_DIV:     if (r_dcnt == 6'd30) n_st = ST_OFFS;
            ST_OFFS:    n_st = ST_EMIT_A;
            ST_EMIT_A:  n_st = (r_newer || r_lastp) ? ST_CLOSE : ST_IDLE;
            ST_CLOSE:   n_st = ST_COUNT;
            ST_COUNT:   if (r_i == (SW+1)'(SLOTS)) n_st = ST_SCAN_RD;
            ST_SCAN_RD: n_st = ST_SCAN;
            ST_SCAN:    if (r_i == (SW+1)'(SLOTS - 1)) n_st = ST_NEXT_DIV;
            ST_NEXT_DIV: if (r_dcnt == 6'd30) n_st = ST_NEXT_OFFS;
            ST_NEXT_OFFS: n_st = r_lastp ? ST_IDLE : ST_EMIT_N;
            ST_EMIT_N:  n_st = ST_IDLE;
            default:    n_st = ST_IDLE;
        endcase
    end

    // outputs and memory control
    always_comb begin
        o_busy = (r_st != ST_IDLE);
        o_valid = 1'b0; o_kind = KIND_ACCEPT; o_source = 4'(r_c);
        o_group_mismatch = r_mis; o_slot = 4'd0; o_time_offset = 22'd0;
        o_payload_index = 12'd0; o_count = 16'd0; o_short_round = 1'b0;
        o_last = 1'b0;
        cl_we = 1'b0;
        cl_wd = {r_g, 31'd0, 13'd0};
        sl_we = 1'b0; sl_wa = r_cslot; sl_wd = 16'd0;
        sl_ra = r_i[SW-1:0];
        case (r_st)
            ST_CLEAR: begin
                sl_we = 1'b1; sl_wa = r_i[SW-1:0];
            end
            ST_DECIDE: begin
                if (!r_started[r_c]) begin
                    cl_we = 1'b1;
                    o_valid = 1'b1; o_kind = KIND_LEARNED;
                    o_group_mismatch = 1'b0; o_last = 1'b1;
                end
            end
            ST_EMIT_A: begin
                cl_wd = {r_cl_rd[51:44], r_cur,
                         (r_rs == r_cur && r_rcv != 13'h1FFF) ? 13'(r_rcv + 13'd1) : r_rcv};
                cl_we = 1'b1;
                if (r_rs == r_cur) begin
                    o_valid = 1'b1; o_kind = KIND_ACCEPT; o_slot = 4'(r_cslot);
                    o_time_offset = r_toff; o_payload_index = r_pi;
                    o_last = !(r_newer || r_lastp);
                end else if (!r_newer) begin
                    o_valid = 1'b1; o_kind = KIND_STALE;
                    o_last = !r_lastp;
                end
                sl_ra = r_cslot;
            end
            ST_CLOSE: begin
                sl_we = 1'b1;
                sl_wd = (r_sl_rd != 16'hFFFF) ? 16'(r_sl_rd + 16'd1) : r_sl_rd;
            end
            ST_SCAN: begin
                // a new flush releases the held word
                if (flush) begin
                    o_valid = 1'b1; o_kind = r_h_kind; o_slot = r_h_slot;
                    o_time_offset = r_h_toff; o_count = r_h_count;
                    o_short_round = r_h_short;
                    sl_we = 1'b1; sl_wa = r_i[SW-1:0];
                end
                sl_ra = SW'(r_i + 1'b1);
            end
            ST_NEXT_OFFS: begin
                cl_we = 1'b1;
                cl_wd = {r_cl_rd[51:44], r_cur, r_lastp ? 13'd0 : 13'd1};
                // held word goes out, final when no accept follows
                o_valid = 1'b1; o_kind = r_h_kind; o_slot = r_h_slot;
                o_time_offset = r_h_toff; o_count = r_h_count;
                o_short_round = r_h_short; o_last = r_lastp;
            end
            ST_EMIT_N: begin
                o_valid = 1'b1; o_kind = KIND_ACCEPT; o_slot = 4'(r_cslot);
                o_time_offset = r_toff; o_payload_index = r_pi; o_last = 1'b1;
            end
            default: ;
        endcase
    end

    // sequencing registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_CLEAR; r_i <= '0; r_started <= '0;
        end else begin
            r_st <= n_st;
            case (r_st)
                ST_CLEAR: r_i <= (SW+1)'(r_i + 1'b1);
                ST_IDLE: begin
                    r_c <= ci; r_g <= i_group; r_rs <= i_round_seq;
                    r_pi <= i_packet_index;
                end
                ST_READ: ;
                ST_DECIDE: begin
                    if (!r_started[r_c]) r_started[r_c] <= 1'b1;
                    r_cur <= r_cl_rd[43:13]; r_rcv <= r_cl_rd[12:0];
                    r_mis <= (r_g != r_cl_rd[51:44]);
                    r_newer <= (r_rs > r_cl_rd[43:13]);
                    r_lastp <= (r_ppr != 13'd0) && ({1'b0, r_pi} + 13'd1 == r_ppr);
                    r_q <= r_cl_rd[43:13]; r_rem <= '0; r_dcnt <= '0;
                end
                ST_DIV, ST_NEXT_DIV: begin
                    r_q <= {r_q[29:0], d_ge};
                    r_rem <= d_ge ? d_sub : {r_rem[10:0], r_q[30]};
                    r_dcnt <= 6'(r_dcnt + 6'd1);
                end
                ST_OFFS: begin
                    r_cslot <= r_q[SW-1:0];
                    r_toff <= 22'(r_rem[10:0] * r_spr);
                end
                ST_EMIT_A: begin
                    if (r_rs == r_cur && r_rcv != 13'h1FFF) r_rcv <= 13'(r_rcv + 13'd1);
                    r_i <= '0; r_nz <= '0;
                end
                ST_CLOSE: begin
                    r_i <= '0;
                    r_h_kind <= KIND_CLOSED; r_h_slot <= 4'(r_cslot);
                    r_h_toff <= r_toff; r_h_count <= {3'b0, r_rcv};
                    r_h_short <= (r_rcv != r_ppr);
                end
                ST_COUNT: begin
                    if (r_i != '0 && r_sl_rd != 16'd0) r_nz <= r_nz + 8'sd1;
                    r_i <= (r_i == (SW+1)'(SLOTS)) ? '0 : (SW+1)'(r_i + 1'b1);
                end
                ST_SCAN_RD: ;
                ST_SCAN: begin
                    if (flush) begin
                        r_nz <= r_nz - 8'sd1;
                        r_h_kind <= KIND_FLUSHED; r_h_slot <= 4'(r_i[SW-1:0]);
                        r_h_toff <= 22'd0; r_h_count <= sv; r_h_short <= 1'b0;
                    end
                    r_i <= (SW+1)'(r_i + 1'b1);
                    if (r_i == (SW+1)'(SLOTS - 1)) begin
                        r_cur <= (r_cur + 31'd1) & ROUND_MASK;
                        r_q <= (r_cur + 31'd1) & ROUND_MASK;
                        r_rem <= '0; r_dcnt <= '0;
                    end
                end
                ST_NEXT_OFFS: begin
                    r_cslot <= r_q[SW-1:0];
                    r_toff <= 22'(r_rem[10:0] * r_spr);
                end
                default: ;
            endcase
        end
    end
endmodule

@@ design/prbt_checker.sv @@
// prbt_checker: port-level checks for the tracker core, module prbt_port_checks
// depends on prbt_pkg; bound to packet_round_block_tracker_core
module prbt_port_checks
    import prbt_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_busy,
    input logic       o_valid,
    input logic [2:0] o_kind,
    input logic       o_last
);
    // results only while working
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_busy) else $error("word while idle");
    // learned word ends its input
    a_learn_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_LEARNED) |-> o_last) else $error("learned not last");
    // kind in range
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_kind <= KIND_FLUSHED)) else $error("bad kind");
endmodule

bind packet_round_block_tracker_core prbt_port_checks u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_busy(o_busy), .o_valid(o_valid),
    .o_kind(o_kind), .o_last(o_last)
);
